### rtl/mbps_pkg.sv
// types and constants shared by the masked byte pattern scanner
`timescale 1ns / 1ps
package mbps_pkg;

   localparam int LEN_W   = 7;
   localparam int LIMIT_W = 16;
   localparam int ADDR_W  = 64;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 6;
   localparam int TYPE_W  = 2;
   localparam int CSR_W   = 2;

   localparam logic [TYPE_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_SCAN  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_BEGIN = 2'd2;

   localparam logic [CSR_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_W-1:0] CSR_MAX_MATCHES    = 2'd1;
   localparam logic [CSR_W-1:0] CSR_REGION_BASE    = 2'd2;

   localparam logic [LIMIT_W-1:0] MAX_MATCHES_RESET = 16'h4000;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] mask;
   } pat_entry_type;

   typedef struct packed {
      logic win_shift;
      logic rotate;
      logic load;
   } cell_ctrl_type;

endpackage

### rtl/mbps_req_if.sv
// request channel of the pattern scanner
`timescale 1ns / 1ps
interface mbps_req_if import mbps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [IDX_W-1:0]  entry_index;
   logic [BYTE_W-1:0] entry_value;
   logic [BYTE_W-1:0] entry_mask;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, req_type, entry_index, entry_value, entry_mask, data_byte,
                   input ready);
   modport sink (input valid, req_type, entry_index, entry_value, entry_mask, data_byte,
                 output ready);
endinterface

### rtl/mbps_rsp_if.sv
// result channel of the pattern scanner
`timescale 1ns / 1ps
interface mbps_rsp_if import mbps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  match_address;
   logic [LIMIT_W-1:0] match_number;

   modport source (output valid, match_address, match_number, input ready);
   modport sink (input valid, match_address, match_number, output ready);
endinterface

### rtl/mbps_cell.sv
// one scanner cell: window byte, rotating pattern entry and masked compare
`timescale 1ns / 1ps
module mbps_cell import mbps_pkg::*; (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [BYTE_W-1:0] win_in,
   output logic [BYTE_W-1:0] win_out,
   input  pat_entry_type     pat_in,
   input  pat_entry_type     load_entry,
   output pat_entry_type     pat_out,
   input  logic              active,
   output logic              hit
);

   logic [BYTE_W-1:0] win_ff;
   logic [BYTE_W-1:0] win_in_sel;
   pat_entry_type     pat_ff;
   pat_entry_type     pat_in_sel;

   always_comb begin
      win_in_sel = ctrl.win_shift ? win_in : win_ff;
      if (ctrl.load) begin
         pat_in_sel = load_entry;
      end else if (ctrl.rotate) begin
         pat_in_sel = pat_in;
      end else begin
         pat_in_sel = pat_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in_sel;
      pat_ff <= pat_in_sel;
   end

   assign win_out = win_ff;
   assign pat_out = pat_ff;
   assign hit     = !active || (((win_ff ^ pat_ff.value) & pat_ff.mask) == '0);

endmodule

### rtl/masked_byte_pattern_scanner_unit.sv
// masked byte pattern scanner: chain of compare cells with match counting
// a matching scan item is compared in the compare stage, then its result is registered
// throughput: one item per cycle while the ring is aligned and the result register drains
// a pattern_length write rotates the pattern ring, with ready low until it is aligned
// reset inits CSRs, counters, valids; pattern and window bytes stay undefined until written
`timescale 1ns / 1ps
module masked_byte_pattern_scanner_unit import mbps_pkg::*; #(
   parameter int MAX_PATTERN = 64
) (
   input  logic              clock,
   input  logic              reset,
   mbps_req_if.sink          req_ch,
   mbps_rsp_if.source        rsp_ch,
   input  logic              csr_wr_en,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // configuration
   logic [LEN_W-1:0]   pattern_length_ff, pattern_length_in;
   logic [LIMIT_W-1:0] max_matches_ff, max_matches_in;
   logic [ADDR_W-1:0]  region_base_ff, region_base_in;

   // ring alignment
   logic [IW-1:0]    rot_ff, rot_in;
   logic [IW-1:0]    rot_target;
   logic [LEN_W-1:0] len_use;
   logic             aligned;

   // counters and compare stage
   logic [ADDR_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic [LIMIT_W-1:0] matches_found_ff, matches_found_in;
   logic               p_valid_ff, p_valid_in;
   logic               p_short_ff, p_short_in;
   logic [ADDR_W-1:0]  p_off_ff, p_off_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_address_ff, rsp_address_in;
   logic [LIMIT_W-1:0] rsp_number_ff, rsp_number_in;

   logic               req_fire, scan_fire, load_fire, begin_fire;
   logic [ADDR_W-1:0]  bytes_next;
   logic [LIMIT_W-1:0] limit;
   logic               stopped, all_hit, p_hit, out_blocked, p_stall;
   logic               load_ok;
   logic [IW-1:0]      load_slot;
   int                 slot_sum;

   logic [BYTE_W-1:0]      win_chain [MAX_PATTERN];
   pat_entry_type          pat_chain [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] hit_vec;
   pat_entry_type          load_entry;

   assign len_use    = (int'(pattern_length_ff) > MAX_PATTERN) ?
                       LEN_W'(MAX_PATTERN) : pattern_length_ff;
   assign rot_target = (len_use == '0) ? '0 : IW'(MAX_PATTERN - int'(len_use));
   assign aligned    = (rot_ff == rot_target);

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign scan_fire  = req_fire && (req_ch.req_type == REQ_SCAN);
   assign load_fire  = req_fire && (req_ch.req_type == REQ_LOAD);
   assign begin_fire = req_fire && (req_ch.req_type == REQ_BEGIN);

   // pattern position maps onto the ring slot shifted by the rotation
   assign load_ok    = int'(req_ch.entry_index) < MAX_PATTERN;
   assign slot_sum   = int'(req_ch.entry_index) + int'(rot_ff);
   assign load_slot  = (slot_sum >= MAX_PATTERN) ? IW'(slot_sum - MAX_PATTERN) : IW'(slot_sum);
   assign load_entry = '{value: req_ch.entry_value, mask: req_ch.entry_mask};

   for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [BYTE_W-1:0] win_in;
      pat_entry_type     pat_in;
      logic              active;

      assign ctrl.win_shift = scan_fire;
      assign ctrl.rotate    = !aligned;
      assign ctrl.load      = load_fire && load_ok && (load_slot == IW'(c));
      assign active         = (int'(len_use) + c) >= MAX_PATTERN;

      if (c == MAX_PATTERN - 1) begin : g_head
         assign win_in = req_ch.data_byte;
      end else begin : g_body
         assign win_in = win_chain[c+1];
      end

      if (c == 0) begin : g_wrap
         assign pat_in = pat_chain[MAX_PATTERN-1];
      end else begin : g_link
         assign pat_in = pat_chain[c-1];
      end

      mbps_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .win_in     (win_in),
         .win_out    (win_chain[c]),
         .pat_in     (pat_in),
         .load_entry (load_entry),
         .pat_out    (pat_chain[c]),
         .active     (active),
         .hit        (hit_vec[c])
      );
   end

   assign all_hit     = &hit_vec;
   assign limit       = (max_matches_ff == '0) ? LIMIT_W'(1) : max_matches_ff;
   assign stopped     = matches_found_ff >= limit;
   assign p_hit       = p_valid_ff && !p_short_ff && (len_use != '0) && !stopped && all_hit;
   assign out_blocked = rsp_valid_ff && !rsp_ch.ready;
   assign p_stall     = p_hit && out_blocked;
   assign bytes_next  = bytes_seen_ff + ADDR_W'(1);

   assign req_ch.ready = aligned && !p_stall;

   always_comb begin
      pattern_length_in = pattern_length_ff;
      max_matches_in    = max_matches_ff;
      region_base_in    = region_base_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: pattern_length_in = csr_wdata[LEN_W-1:0];
            CSR_MAX_MATCHES:    max_matches_in    = csr_wdata[LIMIT_W-1:0];
            CSR_REGION_BASE:    region_base_in    = csr_wdata;
            default:            ;
         endcase
      end
   end

   always_comb begin
      rot_in = rot_ff;
      if (!aligned) begin
         rot_in = (rot_ff == IW'(MAX_PATTERN - 1)) ? '0 : rot_ff + IW'(1);
      end
   end

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      if (begin_fire) begin
         bytes_seen_in = '0;
      end else if (scan_fire) begin
         bytes_seen_in = bytes_next;
      end

      matches_found_in = matches_found_ff;
      if (begin_fire) begin
         matches_found_in = '0;
      end else if (p_hit && !p_stall) begin
         matches_found_in = matches_found_ff + LIMIT_W'(1);
      end

      p_valid_in = p_stall || scan_fire;
      p_off_in   = p_off_ff;
      p_short_in = p_short_ff;
      if (scan_fire) begin
         p_off_in   = bytes_next - ADDR_W'(len_use);
         p_short_in = bytes_next < ADDR_W'(len_use);
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_address_in = rsp_address_ff;
      rsp_number_in  = rsp_number_ff;
      if (p_hit && !out_blocked) begin
         rsp_valid_in   = 1'b1;
         rsp_address_in = region_base_ff + p_off_ff;
         rsp_number_in  = matches_found_ff + LIMIT_W'(1);
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         max_matches_ff    <= MAX_MATCHES_RESET;
         region_base_ff    <= '0;
         rot_ff            <= '0;
         bytes_seen_ff     <= '0;
         matches_found_ff  <= '0;
         p_valid_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         max_matches_ff    <= max_matches_in;
         region_base_ff    <= region_base_in;
         rot_ff            <= rot_in;
         bytes_seen_ff     <= bytes_seen_in;
         matches_found_ff  <= matches_found_in;
         p_valid_ff        <= p_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_off_ff       <= p_off_in;
      p_short_ff     <= p_short_in;
      rsp_address_ff <= rsp_address_in;
      rsp_number_ff  <= rsp_number_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.match_address = rsp_address_ff;
   assign rsp_ch.match_number  = rsp_number_ff;

   // a new result only comes from a scan item in the compare stage
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(p_valid_ff))
      else $error("result appeared without a scan item in compare stage");

   // the ring keeps rotating until it lines up with the pattern length
   a_ring_moves: assert property (@(posedge clock) disable iff (reset)
      (!aligned && !csr_wr_en) |=> (rot_ff != $past(rot_ff)))
      else $error("pattern ring stalled while misaligned");

   // a held compare stage keeps its item
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      p_stall |=> (p_valid_ff && $stable(p_off_ff)))
      else $error("compare stage lost its item during a stall");

   // match ordinals start at one
   a_number_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_number_ff != '0))
      else $error("match ordinal of zero");

endmodule
